// ----- sv/bap_pkg.sv -----
// Package for block_average_pixelation: constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
package bap_pkg;
    localparam int MAX_IMAGE_SIDE_C   = 8192;
    localparam int MAX_CELL_COLUMNS_C = 1024;
    localparam int MAX_CELL_SIZE_C    = 256;
    localparam int MIN_CELL           = 8;
    localparam int SUM_W              = 24;
    localparam int CNT_W              = 17;
    localparam int ACC_W              = 4 * SUM_W + CNT_W;

    localparam logic [2:0] REG_RECT_LEFT    = 3'd0;
    localparam logic [2:0] REG_RECT_TOP     = 3'd1;
    localparam logic [2:0] REG_RECT_WIDTH   = 3'd2;
    localparam logic [2:0] REG_RECT_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_BLOCK_SIZE   = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_ADD, ST_DIV, ST_OUT
    } state_t;

    typedef struct packed {
        logic [12:0] dest_x;
        logic [12:0] dest_y;
        logic [8:0]  fill_width;
        logic [8:0]  fill_height;
        logic [31:0] block_argb;
        logic        last_block;
    } result_t;
endpackage

// ----- sv/bap_if.sv -----
// Channel interfaces: pixel in, result out, config write.
// Depends on nothing.
`timescale 1ns / 1ps
interface bap_pix_if;
    logic        valid;
    logic        ready;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [31:0] pixel_argb;
    modport source (output valid, pixel_x, pixel_y, pixel_argb, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_argb, output ready);
endinterface

interface bap_res_if;
    logic        valid;
    logic        ready;
    logic [12:0] dest_x;
    logic [12:0] dest_y;
    logic [8:0]  fill_width;
    logic [8:0]  fill_height;
    logic [31:0] block_argb;
    logic        last_block;
    modport source (output valid, dest_x, dest_y, fill_width, fill_height, block_argb,
                    last_block, input ready);
    modport sink   (input valid, dest_x, dest_y, fill_width, fill_height, block_argb,
                    last_block, output ready);
endinterface

interface bap_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/bap_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/bap_div.sv -----
// Restoring divider: 24-bit sum / 17-bit count, one quotient bit a cycle,
// saturated to 8 bits. Depends on bap_pkg.
`timescale 1ns / 1ps
module bap_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [7:0]  quotient
);
    import bap_pkg::*;

    logic [23:0] quo_reg, quo_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [17:0] trial;
    logic [17:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[16:0], quo_reg[23]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial;
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = !busy_reg;
    assign quotient = (quo_reg[23:8] != 16'd0) ? 8'hFF : quo_reg[7:0];
endmodule

// ----- sv/block_average_pixelation.sv -----
// Top level of the block-average mosaic engine.
// Depends on bap_pkg, bap_if, bap_ram, bap_div.
`timescale 1ns / 1ps
//
//  channel  dir  handshake      payload
//  pix      in   valid/ready    pixel_x, pixel_y, pixel_argb
//  res      out  valid/ready    dest_x, dest_y, fill_width/height, block_argb, last_block
//  cfg      in   valid/ready    index, data
//
// Pixels outside the image are taken in ST_IDLE and dropped. In-image pixels
// pass from ST_IDLE through ST_DIV (serial x/e, y/e quotient) to ST_READ; a
// pixel that misses the rectangle ends there, a hit adds the read-modify-write
// state ST_ADD. A cell-closing pixel then waits in ST_OUT for the four serial
// dividers, one per channel, and, while the output register still holds an
// unaccepted result, for that register to be free before it is loaded.
// After reset a clearing pass walks the accumulator memory, one column per
// cycle; no pixel is taken during it, but config is. Otherwise config is taken
// when idle and no pixel is offered, never while a pixel is in flight.
module block_average_pixelation #(
    parameter int MAX_IMAGE_SIDE   = bap_pkg::MAX_IMAGE_SIDE_C,
    parameter int MAX_CELL_COLUMNS = bap_pkg::MAX_CELL_COLUMNS_C,
    parameter int MAX_CELL_SIZE    = bap_pkg::MAX_CELL_SIZE_C
) (
    input  logic clk,
    input  logic rst_n,
    bap_pix_if.sink   pix,
    bap_res_if.source res,
    bap_cfg_if.sink   cfg
);
    import bap_pkg::*;

    localparam int AW  = $clog2(MAX_CELL_COLUMNS);
    localparam int CSW = $clog2(MAX_CELL_SIZE + 1);
    localparam int QW  = $clog2(MAX_IMAGE_SIDE);

    // configuration
    logic signed [13:0] rect_left_reg, rect_top_reg;
    logic [13:0] rect_width_reg, rect_height_reg, image_width_reg, image_height_reg;
    logic [8:0]  block_size_reg;

    state_t state_reg, state_next;
    logic   clr_reg, clr_next;
    logic [AW-1:0] clr_addr_reg;

    // latched pixel and derived geometry
    logic [12:0] px_reg, py_reg;
    logic [31:0] argb_reg;
    logic [QW-1:0] qx_reg, qy_reg, qdiv_cnt_reg;
    logic [12:0] rx_reg, ry_reg;

    // cell size
    logic [9:0] e_raw;
    logic [CSW-1:0] e;
    always_comb
    begin
        e_raw = {1'b0, block_size_reg};
        if (e_raw < 10'(MIN_CELL))
        begin
            e_raw = 10'(MIN_CELL);
        end
        if (32'(e_raw) > MAX_CELL_SIZE)
        begin
            e = CSW'(MAX_CELL_SIZE);
        end
        else
        begin
            e = CSW'(e_raw);
        end
    end

    // geometry from quotients (valid in ST_READ and later)
    logic signed [16:0] lft, top, rgt, bot, cx0, cy0, cx1, cy1, iw, ih;
    logic signed [16:0] fx0, fy0, fx1, fy1, lastx, lasty, lx0, ly0;
    logic hit, closes, in_img, is_last;
    always_comb
    begin
        lft = 17'(rect_left_reg);
        top = 17'(rect_top_reg);
        rgt = lft + 17'(signed'({1'b0, rect_width_reg})) - 17'sd1;
        bot = top + 17'(signed'({1'b0, rect_height_reg})) - 17'sd1;
        iw  = 17'(signed'({1'b0, image_width_reg}));
        ih  = 17'(signed'({1'b0, image_height_reg}));
        cx0 = 17'(signed'({1'b0, px_reg})) - 17'(signed'({1'b0, rx_reg}));
        cy0 = 17'(signed'({1'b0, py_reg})) - 17'(signed'({1'b0, ry_reg}));
        cx1 = cx0 + 17'(signed'({1'b0, e})) - 17'sd1;
        cy1 = cy0 + 17'(signed'({1'b0, e})) - 17'sd1;
        hit = !(cx0 > rgt || cx1 < lft || cy0 > bot || cy1 < top)
              && rect_width_reg != 14'd0 && rect_height_reg != 14'd0;
        closes = (17'(signed'({1'b0, px_reg})) == ((cx1 < iw) ? cx1 : iw - 17'sd1))
              && (17'(signed'({1'b0, py_reg})) == ((cy1 < ih) ? cy1 : ih - 17'sd1));
        fx0 = (cx0 > lft) ? cx0 : lft;
        fy0 = (cy0 > top) ? cy0 : top;
        fx1 = (cx1 < rgt) ? cx1 : rgt;
        fy1 = (cy1 < bot) ? cy1 : bot;
        lastx = (rgt < iw - 17'sd1) ? rgt : iw - 17'sd1;
        lasty = (bot < ih - 17'sd1) ? bot : ih - 17'sd1;
        // last cell: lastx lies inside [cx0, cx1] and lasty inside [cy0, cy1]
        lx0 = lastx - cx0;
        ly0 = lasty - cy0;
        is_last = !lastx[16] && !lasty[16] && !lx0[16] && !ly0[16]
                  && lastx <= cx1 && lasty <= cy1;
    end
    assign in_img = ({1'b0, pix.pixel_x} < image_width_reg)
                 && ({1'b0, pix.pixel_y} < image_height_reg);

    // accumulator memory
    logic         mem_we;
    logic [AW-1:0] mem_waddr, col;
    logic [ACC_W-1:0] mem_wdata, mem_rdata, acc_reg, acc_next;
    assign col = AW'(qx_reg);

    bap_ram #(.WIDTH(ACC_W), .DEPTH(MAX_CELL_COLUMNS)) u_acc (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (col),
        .rdata (mem_rdata)
    );

    // dividers start from the updated sums of the closing pixel
    logic        div_start;
    logic [3:0]  div_done;
    logic [7:0]  quo [4];
    logic [16:0] cnt_sum;
    assign cnt_sum = acc_reg[CNT_W-1:0];
    for (genvar g = 0; g < 4; g++)
    begin : g_div
        bap_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (acc_next[CNT_W + g*SUM_W +: SUM_W]),
            .divisor  (acc_next[CNT_W-1:0]),
            .done     (div_done[g]),
            .quotient (quo[g])
        );
    end

    result_t res_reg, res_next, out_reg, out_next;
    logic close_reg, close_next, last_reg, last_next;
    logic out_valid_reg, out_valid_next;

    // count never zero at emission for a raster hit, but keep the gray case
    logic [31:0] color;
    assign color = (cnt_sum == '0) ? 32'hFF808080 : {quo[3], quo[2], quo[1], quo[0]};

    // x/e and y/e by repeated subtraction, one step a cycle would be slow;
    // instead step the quotient with a narrow divider: x - q*e via
    // restoring division, one bit a cycle, both axes in parallel.
    logic [12:0] rx_next, ry_next;
    logic [QW-1:0] qx_next, qy_next, qdiv_cnt_next;
    logic [13:0] trx, try_;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        mem_we        = 1'b0;
        mem_waddr     = col;
        mem_wdata     = '0;
        div_start     = 1'b0;
        res_next      = res_reg;
        close_next    = close_reg;
        last_next     = last_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        qdiv_cnt_next = qdiv_cnt_reg;
        trx = {rx_reg, qx_reg[QW-1]} - 14'(e);
        try_ = {ry_reg, qy_reg[QW-1]} - 14'(e);
        pix.ready     = 1'b0;
        cfg.ready     = 1'b0;
        if (clr_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            cfg.ready = 1'b1;
            if (clr_addr_reg == AW'(MAX_CELL_COLUMNS - 1))
            begin
                clr_next = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    pix.ready = 1'b1;
                    cfg.ready = !pix.valid;
                    if (pix.valid && in_img)
                    begin
                        qx_next = QW'(pix.pixel_x);
                        qy_next = QW'(pix.pixel_y);
                        rx_next = '0;
                        ry_next = '0;
                        qdiv_cnt_next = '0;
                        state_next = ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // quotient/remainder of x and y by e
                    if (!trx[13])
                    begin
                        rx_next = trx[12:0];
                        qx_next = {qx_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rx_next = {rx_reg[11:0], qx_reg[QW-1]};
                        qx_next = {qx_reg[QW-2:0], 1'b0};
                    end
                    if (!try_[13])
                    begin
                        ry_next = try_[12:0];
                        qy_next = {qy_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        ry_next = {ry_reg[11:0], qy_reg[QW-1]};
                        qy_next = {qy_reg[QW-2:0], 1'b0};
                    end
                    qdiv_cnt_next = qdiv_cnt_reg + QW'(1);
                    if (qdiv_cnt_reg == QW'(QW - 1))
                    begin
                        state_next = ST_READ;
                    end
                end
                ST_READ:
                begin
                    // memory read issued at col this cycle
                    state_next = hit ? ST_ADD : ST_IDLE;
                    close_next = closes;
                    last_next  = is_last;
                end
                ST_ADD:
                begin
                    mem_we = 1'b1;
                    mem_wdata[CNT_W-1:0] = mem_rdata[CNT_W-1:0] + CNT_W'(1);
                    for (int k = 0; k < 4; k++)
                    begin
                        mem_wdata[CNT_W + k*SUM_W +: SUM_W] =
                            mem_rdata[CNT_W + k*SUM_W +: SUM_W] + SUM_W'(argb_reg[k*8 +: 8]);
                    end
                    if (close_reg)
                    begin
                        div_start  = 1'b1;
                        res_next.dest_x      = 13'(fx0 - lft);
                        res_next.dest_y      = 13'(fy0 - top);
                        res_next.fill_width  = 9'(fx1 - fx0 + 17'sd1);
                        res_next.fill_height = 9'(fy1 - fy0 + 17'sd1);
                        res_next.last_block  = last_reg;
                        mem_wdata  = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    // hand the result to the output register once all dividers are done and it is free
                    if (div_done == 4'hF && (!out_valid_reg || res.ready))
                    begin
                        out_next            = res_reg;
                        out_next.block_argb = color;
                        out_valid_next      = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // accumulator snapshot for the dividers, with this pixel's contribution
    always_comb
    begin
        acc_next = acc_reg;
        if (state_reg == ST_ADD && !clr_reg)
        begin
            acc_next[CNT_W-1:0] = mem_rdata[CNT_W-1:0] + CNT_W'(1);
            for (int k = 0; k < 4; k++)
            begin
                acc_next[CNT_W + k*SUM_W +: SUM_W] =
                    mem_rdata[CNT_W + k*SUM_W +: SUM_W] + SUM_W'(argb_reg[k*8 +: 8]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            clr_reg          <= 1'b1;
            clr_addr_reg     <= '0;
            out_valid_reg    <= 1'b0;
            rect_left_reg    <= '0;
            rect_top_reg     <= '0;
            rect_width_reg   <= '0;
            rect_height_reg  <= '0;
            block_size_reg   <= 9'd16;
            image_width_reg  <= 14'd8192;
            image_height_reg <= 14'd8192;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_RECT_LEFT:    rect_left_reg    <= cfg.data[13:0];
                    REG_RECT_TOP:     rect_top_reg     <= cfg.data[13:0];
                    REG_RECT_WIDTH:   rect_width_reg   <= cfg.data[13:0];
                    REG_RECT_HEIGHT:  rect_height_reg  <= cfg.data[13:0];
                    REG_BLOCK_SIZE:   block_size_reg   <= cfg.data[8:0];
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg.data[13:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg.data[13:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            px_reg   <= pix.pixel_x;
            py_reg   <= pix.pixel_y;
            argb_reg <= pix.pixel_argb;
        end
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        qdiv_cnt_reg <= qdiv_cnt_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        close_reg    <= close_next;
        last_reg     <= last_next;
        acc_reg      <= acc_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.dest_x      = out_reg.dest_x;
    assign res.dest_y      = out_reg.dest_y;
    assign res.fill_width  = out_reg.fill_width;
    assign res.fill_height = out_reg.fill_height;
    assign res.block_argb  = out_reg.block_argb;
    assign res.last_block  = out_reg.last_block;
endmodule
